// ===== hw/rtl/nrpe_pkg.sv =====
// Package: shared constants and helpers for the RMC position extractor.
package nrpe_pkg;

  // Parameter defaults
  localparam int LINE_BYTES_DEF = 128;
  localparam int LAT_CHARS_DEF  = 15;
  localparam int NS_CHARS_DEF   = 1;
  localparam int LON_CHARS_DEF  = 15;
  localparam int EW_CHARS_DEF   = 1;

  // Storage geometry: four fields of sixteen character slots
  localparam int FIELD_COUNT = 4;
  localparam int FIELD_SLOTS = 16;
  localparam int FIELD_W     = $clog2(FIELD_COUNT);
  localparam int SLOT_W      = $clog2(FIELD_SLOTS);
  localparam int ADDR_W      = FIELD_W + SLOT_W;
  localparam int MEM_DEPTH   = FIELD_COUNT * FIELD_SLOTS;

  // Character codes
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Prefix matcher codes
  localparam logic [2:0] PREFIX_LEN    = 3'd6;
  localparam logic [2:0] PREFIX_FAILED = 3'd7;

  // Token numbering: tokens four to seven carry the position fields
  localparam logic [3:0] TOKEN_FIRST_FIELD = 4'd4;
  localparam logic [3:0] TOKEN_LAST_FIELD  = 4'd7;
  localparam logic [3:0] TOKEN_SAT         = 4'd8;

  // Field identifiers
  localparam logic [1:0] FIELD_LAT = 2'd0;
  localparam logic [1:0] FIELD_NS  = 2'd1;
  localparam logic [1:0] FIELD_LON = 2'd2;
  localparam logic [1:0] FIELD_EW  = 2'd3;

  // Return the expected "$GPRMC" character at a match position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/nrpe_byte_if.sv =====
// Interface: received byte channel.
interface nrpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/nrpe_char_if.sv =====
// Interface: record character result channel.
interface nrpe_char_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_id;
  logic [3:0] char_position;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output field_id, output char_position, output character,
                  output last, input ready);
  modport sink   (input valid, input field_id, input char_position, input character,
                  input last, output ready);
endinterface

// ===== hw/rtl/nmea_rmc_position_extractor.sv =====
// Top level: NMEA RMC line parser with staged and stored position field memories.
//
//   channel | dir | payload                                      | accepted when
//   rx      | in  | rx_byte[7:0]                                 | rx.valid & rx.ready
//   chars   | out | field_id[1:0] char_position[3:0] character[7:0] last | chars.valid & chars.ready
//
// Ready stays high unless the byte ends a "$GPRMC" line.
// A newline that ends a "$GPRMC" line starts a record run of
// LAT_CHARS+NS_CHARS+LON_CHARS+EW_CHARS transactions, each of which may be stalled at the output:
// it reads the memory entry, registers the character and holds it until taken.
// No byte is taken during a run. Reset (rst, synchronous) clears the line state and
// marks every stored field empty; the memories themselves hold no reset value.
module nmea_rmc_position_extractor #(
  parameter int LINE_BYTES = nrpe_pkg::LINE_BYTES_DEF,
  parameter int LAT_CHARS  = nrpe_pkg::LAT_CHARS_DEF,
  parameter int NS_CHARS   = nrpe_pkg::NS_CHARS_DEF,
  parameter int LON_CHARS  = nrpe_pkg::LON_CHARS_DEF,
  parameter int EW_CHARS   = nrpe_pkg::EW_CHARS_DEF
) (
  input logic          clk,
  input logic          rst,
  nrpe_byte_if.sink    rx,
  nrpe_char_if.source  chars
);

  localparam int LL_W = $clog2(LINE_BYTES);
  localparam logic [LL_W-1:0] LINE_MAX = LL_W'(LINE_BYTES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  // Characters kept per field
  function automatic logic [3:0] chars_of(input logic [1:0] fld);
    logic [3:0] n;
    unique case (fld)
      nrpe_pkg::FIELD_LAT: n = 4'(LAT_CHARS);
      nrpe_pkg::FIELD_NS:  n = 4'(NS_CHARS);
      nrpe_pkg::FIELD_LON: n = 4'(LON_CHARS);
      default:             n = 4'(EW_CHARS);
    endcase
    return n;
  endfunction

  logic [1:0]      state;

  // Line state
  logic [LL_W-1:0] line_length, line_length_next;
  logic [2:0]      prefix_progress, prefix_progress_next;
  logic            text_ended, text_ended_next;
  logic [3:0]      token_number, token_number_next;
  logic            inside_token, inside_token_next;
  logic [3:0]      staged_present, staged_present_next;
  logic [3:0]      staged_len [4];
  logic [3:0]      staged_len_next [4];
  logic [3:0]      record_valid;

  // Memories
  logic [7:0] staged_mem [nrpe_pkg::MEM_DEPTH];
  logic [7:0] record_mem [nrpe_pkg::MEM_DEPTH];
  logic                        stage_we;
  logic [nrpe_pkg::ADDR_W-1:0] stage_addr;
  logic [7:0] staged_q, record_q;

  // Run counters and output register
  logic [1:0] fld;
  logic [3:0] pos;
  logic       run_last;
  logic [7:0] load_char;
  logic [1:0] out_field;
  logic [3:0] out_pos;
  logic [7:0] out_char;
  logic       out_last;

  logic       byte_take, start, keep;
  logic [1:0] tok_field;

  assign byte_take = rx.valid && rx.ready;
  assign rx.ready  = (state == ST_IDLE);

  // Parse one byte against the line state
  always_comb begin
    start     = (rx.rx_byte == nrpe_pkg::CH_DOLLAR);
    line_length_next     = start ? '0 : line_length;
    prefix_progress_next = start ? '0 : prefix_progress;
    text_ended_next      = start ? 1'b0 : text_ended;
    token_number_next    = start ? '0 : token_number;
    inside_token_next    = start ? 1'b0 : inside_token;
    staged_present_next  = start ? '0 : staged_present;
    for (int i = 0; i < 4; i++) begin
      staged_len_next[i] = start ? '0 : staged_len[i];
    end
    stage_we   = 1'b0;
    stage_addr = '0;
    tok_field  = token_number_next[1:0];
    keep       = (line_length_next < LINE_MAX);
    if (keep) begin
      line_length_next = line_length_next + 1'b1;
      if (rx.rx_byte == nrpe_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end else if (!text_ended_next) begin
        if (prefix_progress_next < nrpe_pkg::PREFIX_LEN) begin
          prefix_progress_next =
              (rx.rx_byte == nrpe_pkg::prefix_char(prefix_progress_next)) ?
              prefix_progress_next + 1'b1 : nrpe_pkg::PREFIX_FAILED;
        end
        if (rx.rx_byte == nrpe_pkg::CH_COMMA) begin
          inside_token_next = 1'b0;
        end else begin
          if (!inside_token_next) begin
            inside_token_next = 1'b1;
            if (token_number_next < nrpe_pkg::TOKEN_SAT) begin
              token_number_next = token_number_next + 1'b1;
            end
          end
          tok_field = token_number_next[1:0];
          if (token_number_next >= nrpe_pkg::TOKEN_FIRST_FIELD &&
              token_number_next <= nrpe_pkg::TOKEN_LAST_FIELD) begin
            staged_present_next[tok_field] = 1'b1;
            if (staged_len_next[tok_field] < chars_of(tok_field)) begin
              stage_we   = 1'b1;
              stage_addr = {tok_field, staged_len_next[tok_field]};
              staged_len_next[tok_field] = staged_len_next[tok_field] + 1'b1;
            end
          end
        end
      end
    end
  end

  // Pick the record character: fresh staged text or the stored one
  always_comb begin
    if (staged_present[fld]) begin
      load_char = (pos < staged_len[fld]) ? staged_q : nrpe_pkg::CH_NUL;
    end else begin
      load_char = record_valid[fld] ? record_q : nrpe_pkg::CH_NUL;
    end
  end

  assign run_last = (fld == nrpe_pkg::FIELD_EW) && (pos == 4'(EW_CHARS - 1));

  // Control: line state, run sequencing, record field marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      line_length     <= '0;
      prefix_progress <= '0;
      text_ended      <= 1'b0;
      token_number    <= '0;
      inside_token    <= 1'b0;
      staged_present  <= '0;
      for (int i = 0; i < 4; i++) staged_len[i] <= '0;
      record_valid    <= '0;
      fld             <= '0;
      pos             <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (byte_take) begin
            line_length     <= line_length_next;
            prefix_progress <= prefix_progress_next;
            text_ended      <= text_ended_next;
            token_number    <= token_number_next;
            inside_token    <= inside_token_next;
            staged_present  <= staged_present_next;
            for (int i = 0; i < 4; i++) staged_len[i] <= staged_len_next[i];
            if (rx.rx_byte == nrpe_pkg::CH_NEWLINE) begin
              if (prefix_progress_next == nrpe_pkg::PREFIX_LEN) begin
                // hold staged marks for the commit run
                state <= ST_READ;
                fld   <= nrpe_pkg::FIELD_LAT;
                pos   <= '0;
              end else begin
                // drop the line
                line_length     <= '0;
                prefix_progress <= '0;
                text_ended      <= 1'b0;
                token_number    <= '0;
                inside_token    <= 1'b0;
                staged_present  <= '0;
                for (int i = 0; i < 4; i++) staged_len[i] <= '0;
              end
            end
          end
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: begin
          state <= ST_SEND;
          if (staged_present[fld]) record_valid[fld] <= 1'b1;
        end
        ST_SEND: begin
          if (chars.ready) begin
            if (run_last) begin
              // run done: start a fresh line
              state           <= ST_IDLE;
              line_length     <= '0;
              prefix_progress <= '0;
              text_ended      <= 1'b0;
              token_number    <= '0;
              inside_token    <= 1'b0;
              staged_present  <= '0;
              for (int i = 0; i < 4; i++) staged_len[i] <= '0;
            end else begin
              state <= ST_READ;
              if (pos == chars_of(fld) - 1'b1) begin
                fld <= fld + 1'b1;
                pos <= '0;
              end else begin
                pos <= pos + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Staged text memory: write on token bytes, read during the run
  always_ff @(posedge clk) begin
    if (byte_take && stage_we) staged_mem[stage_addr] <= rx.rx_byte;
    if (state == ST_READ) staged_q <= staged_mem[{fld, pos}];
  end

  // Record memory: read during the run, write back committed characters
  always_ff @(posedge clk) begin
    if (state == ST_READ) record_q <= record_mem[{fld, pos}];
    if (state == ST_LOAD && staged_present[fld]) record_mem[{fld, pos}] <= load_char;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      out_field <= fld;
      out_pos   <= pos;
      out_char  <= load_char;
      out_last  <= run_last;
    end
  end

  assign chars.valid         = (state == ST_SEND);
  assign chars.field_id      = out_field;
  assign chars.char_position = out_pos;
  assign chars.character     = out_char;
  assign chars.last          = out_last;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rx.ready |-> !chars.valid)
    else $error("byte taken while a result is pending");

  a_last_field: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.last) |-> (chars.field_id == nrpe_pkg::FIELD_EW))
    else $error("run ends outside the east/west field");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    chars.valid |-> (chars.char_position < chars_of(chars.field_id)))
    else $error("character position beyond field size");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && chars.last) |=> rx.ready)
    else $error("byte channel not reopened after the run");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (chars.valid && $stable(fld) && $stable(pos)))
    else $error("loaded character not presented");

endmodule

// ===== tb/sv/nmea_rmc_position_extractor_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the NMEA RMC position extractor: sentence stimulus, record prediction, checks.
module nmea_rmc_position_extractor_tb;

  localparam int LINE_BYTES = nrpe_pkg::LINE_BYTES_DEF;
  localparam int FIELD_LEN [nrpe_pkg::FIELD_COUNT] = '{nrpe_pkg::LAT_CHARS_DEF,
                                                       nrpe_pkg::NS_CHARS_DEF,
                                                       nrpe_pkg::LON_CHARS_DEF,
                                                       nrpe_pkg::EW_CHARS_DEF};
  localparam int RECORD_LEN = nrpe_pkg::LAT_CHARS_DEF + nrpe_pkg::NS_CHARS_DEF +
                              nrpe_pkg::LON_CHARS_DEF + nrpe_pkg::EW_CHARS_DEF;
  localparam logic [7:0] RMC_TAG [6] = '{nrpe_pkg::CH_DOLLAR, "G", "P", "R", "M", "C"};
  localparam logic [7:0] CH_RETURN = 8'h0D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam int RANDOM_BYTES     = 40;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int END_SETTLE       = 20;

  typedef struct packed {
    logic [1:0] field_id;
    logic [3:0] char_position;
    logic [7:0] character;
    logic       last;
  } record_char_t;

  logic clk = 1'b0;
  logic rst;

  nrpe_byte_if rx_if ();
  nrpe_char_if chars_if ();

  nmea_rmc_position_extractor dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .chars (chars_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Line parser mirror
  int          line_len;
  logic [2:0]  prefix_step;
  bit          text_cut;
  logic [3:0]  token_count;
  bit          in_token;
  int          token_len;
  logic [7:0]  staged_chars [nrpe_pkg::FIELD_COUNT][nrpe_pkg::FIELD_SLOTS];
  logic [nrpe_pkg::FIELD_COUNT-1:0] staged_seen;
  logic [7:0]  stored_chars [nrpe_pkg::FIELD_COUNT][nrpe_pkg::FIELD_SLOTS];

  record_char_t record_chars_due [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic void start_new_line();
    line_len    = 0;
    prefix_step = '0;
    text_cut    = 1'b0;
    token_count = '0;
    in_token    = 1'b0;
    token_len   = 0;
    staged_seen = '0;
    foreach (staged_chars[f, p]) staged_chars[f][p] = nrpe_pkg::CH_NUL;
  endfunction

  // Track prefix match and tokens for one byte the parser can see
  function automatic void scan_visible_byte(input logic [7:0] c);
    int f;
    if (prefix_step < nrpe_pkg::PREFIX_LEN) begin
      if (c == RMC_TAG[prefix_step]) prefix_step = prefix_step + 3'd1;
      else prefix_step = nrpe_pkg::PREFIX_FAILED;
    end
    if (c == nrpe_pkg::CH_COMMA) begin
      in_token = 1'b0;
      return;
    end
    if (!in_token) begin
      in_token = 1'b1;
      if (token_count < nrpe_pkg::TOKEN_SAT) token_count = token_count + 4'd1;
      token_len = 0;
    end
    if (token_count >= nrpe_pkg::TOKEN_FIRST_FIELD &&
        token_count <= nrpe_pkg::TOKEN_LAST_FIELD) begin
      f = int'(token_count - nrpe_pkg::TOKEN_FIRST_FIELD);
      staged_seen[f] = 1'b1;
      if (token_len < FIELD_LEN[f] && token_len < nrpe_pkg::FIELD_SLOTS) begin
        staged_chars[f][token_len] = c;
        token_len++;
      end
    end
  endfunction

  // Advance the mirror by one accepted byte; queue the record run a newline triggers
  function automatic void predict_rx_byte(input logic [7:0] c);
    record_char_t rc;
    int n;
    if (c == nrpe_pkg::CH_DOLLAR) start_new_line();
    if (line_len < LINE_BYTES - 1) begin
      line_len++;
      if (c == nrpe_pkg::CH_NUL) text_cut = 1'b1;
      else if (!text_cut) scan_visible_byte(c);
    end
    if (c != nrpe_pkg::CH_NEWLINE) return;
    if (prefix_step == nrpe_pkg::PREFIX_LEN) begin
      for (int f = 0; f < nrpe_pkg::FIELD_COUNT; f++) begin
        if (staged_seen[f]) stored_chars[f] = staged_chars[f];
      end
      n = 0;
      for (int f = 0; f < nrpe_pkg::FIELD_COUNT; f++) begin
        for (int p = 0; p < FIELD_LEN[f] && p < nrpe_pkg::FIELD_SLOTS; p++) begin
          n++;
          rc.field_id      = 2'(f);
          rc.char_position = 4'(p);
          rc.character     = stored_chars[f][p];
          rc.last          = (n == RECORD_LEN);
          record_chars_due.push_back(rc);
        end
      end
    end
    start_new_line();
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted record character with the oldest expectation
  always @(posedge clk) begin
    record_char_t want;
    if (!rst && chars_if.valid === 1'b1 && chars_if.ready === 1'b1) begin
      if (record_chars_due.size() == 0) begin
        $display({"%0t: unexpected transaction, expected none, ",
                  "actual field %0h pos %0h char %0h last %0b"},
                 $time, chars_if.field_id, chars_if.char_position, chars_if.character,
                 chars_if.last);
        mismatch_count++;
      end else begin
        want = record_chars_due.pop_front();
        check_field("field_id", 8'(want.field_id), 8'(chars_if.field_id));
        check_field("char_position", 8'(want.char_position), 8'(chars_if.char_position));
        check_field("character", want.character, chars_if.character);
        check_field("last", 8'(want.last), 8'(chars_if.last));
      end
    end
  end

  // Stall the record channel: ready runs of random length, short stalls, some long open stretches
  initial begin : sink_stall
    int  hold_left;
    bit  hold_level;
    hold_left  = 0;
    hold_level = 1'b0;
    chars_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_level && $urandom_range(0, 2) != 0) begin
        hold_level = 1'b0;
        hold_left  = $urandom_range(0, 5);
      end else begin
        hold_level = 1'b1;
        hold_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 11);
      end
      chars_if.ready <= hold_level;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
        (chars_if.valid === 1'b1 && chars_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("nmea_rmc_position_extractor test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte in bursts with random gaps, hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    predict_rx_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the sender until every expected record character has come
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (record_chars_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_token_char();
    logic [7:0] c;
    if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(1, 255));
    else c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == nrpe_pkg::CH_COMMA || c == nrpe_pkg::CH_DOLLAR || c == nrpe_pkg::CH_NEWLINE) begin
      c = CH_DOT;
    end
    return c;
  endfunction

  // Build one random line: mostly RMC sentences, some broken prefixes, some noise
  function automatic void build_random_line(ref logic [7:0] q[$]);
    int kind;
    int n_tok;
    int len;
    int cut;
    q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      for (int i = 0; i < nrpe_pkg::PREFIX_LEN; i++) q.push_back(RMC_TAG[i]);
      n_tok = $urandom_range(2, 9);
      repeat (n_tok) begin
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1) begin
          q.push_back(nrpe_pkg::CH_COMMA);
        end
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom_range(13, 18);
          default: len = $urandom_range(1, 4);
        endcase
        repeat (len) q.push_back(pick_token_char());
      end
      if ($urandom_range(0, 7) == 0) q.insert($urandom_range(1, q.size()), nrpe_pkg::CH_NUL);
      if ($urandom_range(0, 9) == 0) q.push_back(CH_RETURN);
      q.push_back(nrpe_pkg::CH_NEWLINE);
    end else if (kind < 88) begin
      cut = $urandom_range(1, 5);
      for (int i = 0; i < cut; i++) q.push_back(RMC_TAG[i]);
      if ($urandom_range(0, 1) == 1) q.push_back(pick_token_char());
      repeat (3) begin
        q.push_back(nrpe_pkg::CH_COMMA);
        q.push_back(pick_token_char());
      end
      q.push_back(nrpe_pkg::CH_NEWLINE);
    end else begin
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_reference_sentences();
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4\n");
    // long latitude cut to size, top-bit bytes in longitude, comma runs
    send_text("$GPRMC,a,,b,0123456789ABCDEFG,,S,");
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_text(",W\n");
  endtask

  task automatic test_prefix_rejects();
    send_text("$GPRMX,1,2,3,4,5\n");
    send_text("$GP\n");
    send_text("GPRMC,1,2,3,4,5\n");
  endtask

  task automatic test_cut_lines();
    string s;
    // newline that fits lands in the east/west token
    send_text("$GPRMC,1,2,3,4,5,\n");
    // zero byte hides the rest of the line
    send_text("$GPRMC,1,2,77");
    send_byte(nrpe_pkg::CH_NUL);
    send_text(",X,Y,Z\n");
    // dollar in the middle restarts the line
    send_text("xy$GPRMC,1,2,8,9,0,1\n");
    // overlong line: late fields dropped, a late dollar still restarts
    s = "$GPRMC,1,2,";
    repeat (116) s = {s, "a"};
    send_text({s, ",L,N,M,E"});
    // restarted line is overlong too: its late newline still ends it
    s = "$GPRMC,1,2,";
    repeat (117) s = {s, "b"};
    send_text({s, ",L,N,M,E\n"});
  endtask

  task automatic test_random_stream();
    logic [7:0] line_q [$];
    int         sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_random_line(line_q);
      foreach (line_q[i]) send_byte(line_q[i]);
      sent += line_q.size();
    end
  endtask

  initial begin
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    start_new_line();
    foreach (stored_chars[f, p]) stored_chars[f][p] = nrpe_pkg::CH_NUL;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reference_sentences();
    test_prefix_rejects();
    test_cut_lines();
    drain_results();
    test_random_stream();
    drain_results();

    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && record_chars_due.size() == 0) begin
      $display("nmea_rmc_position_extractor test passed");
    end else begin
      $display("nmea_rmc_position_extractor test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nrpe_pkg.sv
hw/rtl/nrpe_byte_if.sv
hw/rtl/nrpe_char_if.sv
hw/rtl/nmea_rmc_position_extractor.sv
tb/sv/nmea_rmc_position_extractor_tb.sv
